>>> hdl/dlr_pkg.sv
package dlr_pkg;

  localparam int COORD_BITS  = 10;
  localparam int COLOR_BITS  = 32;
  localparam int PERIOD_BITS = 8;

  typedef logic [COORD_BITS-1:0]  coord_t;
  typedef logic [COORD_BITS:0]    err_t;
  typedef logic [COLOR_BITS-1:0]  color_t;
  typedef logic [PERIOD_BITS-1:0] period_t;

  typedef enum logic {
    ACT_START = 1'b0,
    ACT_STEP  = 1'b1
  } action_t;

  typedef struct packed {
    action_t action;
    coord_t  x_start;
    coord_t  y_start;
    coord_t  x_end;
    coord_t  y_end;
    color_t  line_color;
    period_t dash_period;
  } in_item_t;

  typedef struct packed {
    logic   has_pixel;
    coord_t pixel_x;
    coord_t pixel_y;
    color_t pixel_color;
    logic   visible;
    logic   last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;        // latch a new line from the input item
    logic advance;     // walk one pixel
    logic emit_pixel;  // fill output register with the current pixel
    logic emit_idle;   // fill output register with an empty result
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic line_nonzero;  // line on the input has at least one pixel
    logic last;          // current pixel is the final one
  } dp_status_t;

endpackage

>>> hdl/dlr_datapath.sv
module dlr_datapath
  import dlr_pkg::*;
(
  input  logic       clk,
  input  in_item_t   in_data,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  output out_item_t  out_data
);

  coord_t  cur_x;
  coord_t  cur_y;
  err_t    error_acc;
  coord_t  major_delta;
  coord_t  minor_delta;
  coord_t  total_pixels;
  coord_t  pixel_index;
  logic    x_down;
  logic    y_down;
  logic    x_major;
  color_t  held_color;
  period_t held_period;
  period_t dash_phase;

  // start setup
  logic   ld_x_down;
  logic   ld_y_down;
  logic   ld_x_major;
  coord_t ld_dx;
  coord_t ld_dy;
  coord_t ld_major;
  coord_t ld_minor;

  always_comb begin
    ld_x_down  = in_data.x_end < in_data.x_start;
    ld_y_down  = in_data.y_end < in_data.y_start;
    ld_dx      = ld_x_down ? in_data.x_start - in_data.x_end
                           : in_data.x_end - in_data.x_start;
    ld_dy      = ld_y_down ? in_data.y_start - in_data.y_end
                           : in_data.y_end - in_data.y_start;
    ld_x_major = ld_dx >= ld_dy;
    ld_major   = ld_x_major ? ld_dx : ld_dy;
    ld_minor   = ld_x_major ? ld_dy : ld_dx;
  end

  // one bresenham step
  err_t    err_sum;
  logic    minor_step;
  err_t    error_acc_next;
  coord_t  cur_x_next;
  coord_t  cur_y_next;
  coord_t  x_stepped;
  coord_t  y_stepped;
  period_t phase_inc;
  period_t dash_phase_next;
  logic    visible;

  always_comb begin
    err_sum        = error_acc + {1'b0, minor_delta};
    minor_step     = err_sum >= {1'b0, major_delta};
    error_acc_next = minor_step ? err_sum - {1'b0, major_delta} : err_sum;
    x_stepped      = x_down ? cur_x - coord_t'(1) : cur_x + coord_t'(1);
    y_stepped      = y_down ? cur_y - coord_t'(1) : cur_y + coord_t'(1);
    if (x_major) begin
      cur_x_next = x_stepped;
      cur_y_next = minor_step ? y_stepped : cur_y;
    end else begin
      cur_y_next = y_stepped;
      cur_x_next = minor_step ? x_stepped : cur_x;
    end
    // phase stays below the period, so the increment never wraps
    phase_inc = dash_phase + period_t'(1);
    if (held_period == '0) begin
      dash_phase_next = dash_phase;
    end else if (phase_inc >= held_period) begin
      dash_phase_next = '0;
    end else begin
      dash_phase_next = phase_inc;
    end
    visible = (held_period == '0) || (dash_phase >= (held_period >> 1));
  end

  always_comb begin
    status.line_nonzero = ld_major != '0;
    status.last         = pixel_index == total_pixels;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_x        <= in_data.x_start;
      cur_y        <= in_data.y_start;
      error_acc    <= {1'b0, ld_major >> 1};
      major_delta  <= ld_major;
      minor_delta  <= ld_minor;
      total_pixels <= ld_major;
      pixel_index  <= coord_t'(1);
      x_down       <= ld_x_down;
      y_down       <= ld_y_down;
      x_major      <= ld_x_major;
      held_color   <= in_data.line_color;
      held_period  <= in_data.dash_period;
      // 1 mod period
      dash_phase   <= (in_data.dash_period > period_t'(1)) ? period_t'(1) : '0;
    end else if (cmd.advance) begin
      cur_x       <= cur_x_next;
      cur_y       <= cur_y_next;
      error_acc   <= error_acc_next;
      dash_phase  <= dash_phase_next;
      pixel_index <= pixel_index + coord_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_pixel) begin
      out_data.has_pixel   <= 1'b1;
      out_data.pixel_x     <= cur_x;
      out_data.pixel_y     <= cur_y;
      out_data.pixel_color <= held_color;
      out_data.visible     <= visible;
      out_data.last        <= status.last;
    end else if (cmd.emit_idle) begin
      out_data <= '0;
    end
  end

endmodule

>>> hdl/dlr_ctrl.sv
module dlr_ctrl
  import dlr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  action_t    action,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DRAW = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   take;
  logic   take_start;
  logic   take_step;

  always_comb begin
    in_stall   = out_valid && out_stall;
    take       = in_valid && !in_stall;
    take_start = take && (action == ACT_START);
    take_step  = take && (action == ACT_STEP);

    cmd.load       = take_start;
    cmd.advance    = take_step && (state == ST_DRAW);
    cmd.emit_pixel = take_step && (state == ST_DRAW);
    cmd.emit_idle  = take_step && (state == ST_IDLE);

    if (take_step) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end

    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (take_start && status.line_nonzero) begin
          state_next = ST_DRAW;
        end
      end
      ST_DRAW: begin
        if (take_start) begin
          state_next = status.line_nonzero ? ST_DRAW : ST_IDLE;
        end else if (take_step && status.last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

>>> hdl/dashed_line_rasterizer.sv
// channel  | handshake                 | payload
// ---------+---------------------------+-----------------------------------
// in       | in_valid / in_stall       | in_data  (in_item_t: start or step)
// out      | out_valid / out_stall     | out_data (out_item_t: one pixel or an empty result)
//
// an item is taken when in_valid is high and in_stall low; one item per cycle sustained while in_stall stays low
// the combinational bresenham step (error add, compare, coordinate update) sets that
// a start item yields no result; a step item yields one result through the output register
// synchronous active-high reset idles the walker and clears out_valid
// the output register is the only buffer: in_stall follows a full, stalled output

module dashed_line_rasterizer
  import dlr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // command and status between controller and datapath
  dp_cmd_t    cmd;
  dp_status_t status;

  // controller: line active / idle, handshake and output register valid
  dlr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .action    (in_data.action),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath: endpoint setup, error accumulator, dash counter, output register
  dlr_datapath u_datapath (
    .clk      (clk),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule
